// ===== hdl/pds_pkg.sv =====
// shared types, constants and helpers of the percent decoder stream
package pds_pkg;

   localparam int CHAR_W = 16;
   localparam int MAX_UNITS = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam logic [CHAR_W-1:0] PERCENT_UNIT = 16'h0025;

   typedef struct packed {
      logic [MAX_UNITS-1:0][CHAR_W-1:0] chars;
      logic [1:0]                       count;
      logic                             has_char;
      logic                             last;
   } pkt_type;

   function automatic logic is_hex(input logic [CHAR_W-1:0] c);
      return (c >= 16'h0030 && c <= 16'h0039) ||
             (c >= 16'h0041 && c <= 16'h0046) ||
             (c >= 16'h0061 && c <= 16'h0066);
   endfunction

   function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         d = c - 16'h0030;
      end else if (c >= 16'h0041 && c <= 16'h0046) begin
         d = c - 16'h0037;
      end else if (c >= 16'h0061 && c <= 16'h0066) begin
         d = c - 16'h0057;
      end
      return d[3:0];
   endfunction

endpackage

// ===== hdl/pds_front.sv =====
// front end: accepts input beats, tracks pending escapes, builds result packets
module pds_front
   import pds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char,
   input  logic              req_last,
   input  logic              q_full,
   output logic              q_push,
   output pkt_type           q_pkt
);

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_ONE  = 2'd1,
      PEND_TWO  = 2'd2
   } pend_type;

   pend_type   pend_ff, pend_in;
   logic [6:0] held_ff, held_in;
   logic [1:0] n;
   logic [MAX_UNITS-1:0][CHAR_W-1:0] chars;
   logic       accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic       idle_step;
      logic       hex;
      logic [7:0] v;
      idle_step = 1'b0;
      hex       = is_hex(req_char);
      v         = {hex_value({9'd0, held_ff}), hex_value(req_char)};
      n         = '0;
      chars     = '0;
      pend_in   = pend_ff;
      held_in   = held_ff;
      unique case (pend_ff)
         PEND_ONE: begin
            if (hex) begin
               pend_in = PEND_TWO;
               held_in = req_char[6:0];
            end else begin
               chars[n] = PERCENT_UNIT;
               n = n + 2'd1;
               idle_step = 1'b1;
            end
         end
         PEND_TWO: begin
            if (hex) begin
               pend_in = PEND_NONE;
               if (v != 8'd0) begin
                  chars[n] = {8'd0, v};
                  n = n + 2'd1;
               end
            end else begin
               chars[n] = PERCENT_UNIT;
               n = n + 2'd1;
               chars[n] = {9'd0, held_ff};
               n = n + 2'd1;
               idle_step = 1'b1;
            end
         end
         default: idle_step = 1'b1;
      endcase
      if (idle_step) begin
         if (req_char == PERCENT_UNIT) begin
            pend_in = PEND_ONE;
         end else begin
            pend_in = PEND_NONE;
            chars[n] = req_char;
            n = n + 2'd1;
         end
      end
      if (req_last) begin
         // at most three beats per packet, a further flushed percent is dropped
         if (pend_in != PEND_NONE && n != 2'd3) begin
            chars[n] = PERCENT_UNIT;
            n = n + 2'd1;
         end
         if (pend_in == PEND_TWO) begin
            chars[n] = {9'd0, held_in};
            n = n + 2'd1;
         end
         pend_in = PEND_NONE;
      end
   end

   assign q_push         = accept && (n != 2'd0 || req_last);
   assign q_pkt.chars    = chars;
   assign q_pkt.count    = (n == 2'd0) ? 2'd1 : n;
   assign q_pkt.has_char = (n != 2'd0);
   assign q_pkt.last     = req_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
         held_ff <= '0;
      end else if (accept) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== hdl/pds_queue.sv =====
// short packet queue between front and back end
module pds_queue
   import pds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pkt_type push_pkt,
   output logic    full,
   input  logic    pop,
   output pkt_type head_pkt,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   pkt_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_pkt = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/pds_back.sv =====
// back end: unpacks queued packets into single result beats
module pds_back
   import pds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pkt_type           head_pkt,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_char,
   output logic              rsp_has_char,
   output logic              rsp_last
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              has_ff, has_in;
   logic              last_ff, last_in;
   logic              load, at_end;

   assign load   = (!valid_ff || rsp_ready) && !q_empty;
   assign at_end = (idx_ff == head_pkt.count - 2'd1);
   assign q_pop  = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = (idx_ff < 2'd3) ? head_pkt.chars[idx_ff] : '0;
         has_in   = head_pkt.has_char;
         last_in  = head_pkt.last && at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_char     = char_ff;
   assign rsp_has_char = has_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== hdl/percent_decoder_stream_unit.sv =====
// top level of the streaming percent-escape decoder
//
//   channel  direction  beat fields
//   req_     in         req_char[15:0], req_last
//   rsp_     out        rsp_char[15:0], rsp_has_char, rsp_last
//
// one input beat accepted per cycle while the packet queue has room
// each input beat yields zero to three result beats, one per cycle from the back end while rsp_ready is high
// result beats are held first in the packet queue, then in the registered back end output
// synchronous reset returns to no pending escape and an empty queue
// a stalled rsp_ fills the queue, then req_ready drops
module percent_decoder_stream_unit
   import pds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_char,
   output logic              rsp_has_char,
   output logic              rsp_last
);

   pkt_type push_pkt, head_pkt;
   logic    q_push, q_full, q_pop, q_empty;

   pds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_char  (req_char),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_pkt     (push_pkt)
   );

   pds_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_pkt (push_pkt),
      .full     (q_full),
      .pop      (q_pop),
      .head_pkt (head_pkt),
      .empty    (q_empty)
   );

   pds_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_pkt     (head_pkt),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char     (rsp_char),
      .rsp_has_char (rsp_has_char),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== verif/percent_decoder_stream_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the streaming percent decoder, with directed and random strings
module percent_decoder_stream_unit_test;
   import pds_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_UNITS = 60;
   localparam int REPORT_MAX = 10;

   typedef enum logic [1:0] {
      ESC_IDLE    = 2'd0,
      ESC_PERCENT = 2'd1,
      ESC_DIGIT   = 2'd2
   } esc_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_beat_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              has_char;
      logic              last;
   } decoded_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAR_W-1:0] req_char = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAR_W-1:0] rsp_char;
   logic              rsp_has_char;
   logic              rsp_last;

   text_beat_type     unit_backlog[$];
   decoded_beat_type  due_chars[$];
   esc_type           esc_state = ESC_IDLE;
   logic [6:0]        held_digit = '0;
   logic [CHAR_W-1:0] step_chars [MAX_UNITS];
   int                step_count = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                fail_count = 0;
   int                cycles = 0;

   percent_decoder_stream_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char     (req_char),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char     (rsp_char),
      .rsp_has_char (rsp_has_char),
      .rsp_last     (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit is_hex_unit(input logic [CHAR_W-1:0] c);
      return (c >= 16'h0030 && c <= 16'h0039) ||
             (c >= 16'h0041 && c <= 16'h0046) ||
             (c >= 16'h0061 && c <= 16'h0066);
   endfunction

   function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
      if (c <= 16'h0039) begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   function void add_char(input logic [CHAR_W-1:0] c);
      if (step_count < MAX_UNITS) begin
         step_chars[step_count] = c;
         step_count++;
      end
   endfunction

   // advance the escape state by one input beat and queue the beats it yields
   function void decode_unit(input logic [CHAR_W-1:0] c, input logic last);
      bit               taken;
      logic [7:0]       byte_val;
      decoded_beat_type beat;
      int               i;
      taken = 1'b0;
      step_count = 0;
      case (esc_state)
         ESC_PERCENT: begin
            if (is_hex_unit(c)) begin
               held_digit = c[6:0];
               esc_state = ESC_DIGIT;
               taken = 1'b1;
            end else begin
               add_char(PERCENT_UNIT);
               esc_state = ESC_IDLE;
            end
         end
         ESC_DIGIT: begin
            if (is_hex_unit(c)) begin
               byte_val = {digit_value({9'd0, held_digit}), digit_value(c)};
               esc_state = ESC_IDLE;
               taken = 1'b1;
               if (byte_val != 8'd0) begin
                  add_char({8'd0, byte_val});
               end
            end else begin
               add_char(PERCENT_UNIT);
               add_char({9'd0, held_digit});
               esc_state = ESC_IDLE;
            end
         end
         default: begin
            esc_state = ESC_IDLE;
         end
      endcase
      if (!taken) begin
         if (c == PERCENT_UNIT) begin
            esc_state = ESC_PERCENT;
         end else begin
            add_char(c);
         end
      end
      if (last) begin
         if (esc_state != ESC_IDLE) begin
            add_char(PERCENT_UNIT);
         end
         if (esc_state == ESC_DIGIT) begin
            add_char({9'd0, held_digit});
         end
         esc_state = ESC_IDLE;
      end
      if (last && step_count == 0) begin
         beat.ch = '0;
         beat.has_char = 1'b0;
         beat.last = 1'b1;
         due_chars.push_back(beat);
      end
      for (i = 0; i < step_count; i++) begin
         beat.ch = step_chars[i];
         beat.has_char = 1'b1;
         beat.last = last && (i == step_count - 1);
         due_chars.push_back(beat);
      end
   endfunction

   function automatic logic [CHAR_W-1:0] random_hex_unit();
      int r;
      r = $urandom_range(21, 0);
      if (r < 10) begin
         return CHAR_W'(16'h0030 + r);
      end else if (r < 16) begin
         return CHAR_W'(16'h0041 + r - 10);
      end
      return CHAR_W'(16'h0061 + r - 16);
   endfunction

   function automatic logic [CHAR_W-1:0] random_plain_unit();
      case ($urandom_range(4, 0))
         0: return CHAR_W'($urandom_range(65535, 0));
         1: return CHAR_W'(16'h0020 + $urandom_range(94, 0));
         2: return random_hex_unit() | CHAR_W'($urandom_range(255, 1) << 8);
         3: begin
            case ($urandom_range(8, 0))
               0: return 16'h002F;
               1: return 16'h003A;
               2: return 16'h0040;
               3: return 16'h0047;
               4: return 16'h0060;
               5: return 16'h0067;
               6: return 16'h0000;
               7: return 16'hFFFF;
               default: return PERCENT_UNIT;
            endcase
         end
         default: return random_hex_unit();
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] random_non_hex();
      logic [CHAR_W-1:0] c;
      c = random_plain_unit();
      if (is_hex_unit(c)) begin
         c = c | 16'h0100;
      end
      return c;
   endfunction

   task automatic add_unit(input logic [CHAR_W-1:0] c, input logic last);
      text_beat_type beat;
      beat.ch = c;
      beat.last = last;
      unit_backlog.push_back(beat);
   endtask

   task automatic add_text(input string s, input bit last_at_end);
      int i;
      for (i = 0; i < s.len(); i++) begin
         add_unit({8'd0, s[i]}, last_at_end && (i == s.len() - 1));
      end
   endtask

   // mostly well-formed escapes with random content, some broken ones and plain noise
   task automatic add_random_string();
      logic [CHAR_W-1:0] units[$];
      int                tokens;
      int                r;
      int                i;
      tokens = $urandom_range(4, 1);
      if ($urandom_range(9, 0) == 0) begin
         repeat (tokens * 2) units.push_back(random_plain_unit());
      end else begin
         repeat (tokens) begin
            r = $urandom_range(19, 0);
            if (r < 10) begin
               units.push_back(PERCENT_UNIT);
               units.push_back(random_hex_unit());
               units.push_back(random_hex_unit());
            end else if (r < 12) begin
               units.push_back(PERCENT_UNIT);
               units.push_back(16'h0030);
               units.push_back(16'h0030);
            end else if (r < 14) begin
               units.push_back(PERCENT_UNIT);
               units.push_back(random_non_hex());
            end else if (r < 16) begin
               units.push_back(PERCENT_UNIT);
               units.push_back(random_hex_unit());
               units.push_back(random_non_hex());
            end else begin
               units.push_back(random_plain_unit());
            end
         end
         r = $urandom_range(4, 0);
         if (r == 0) begin
            units.push_back(PERCENT_UNIT);
         end else if (r == 1) begin
            units.push_back(PERCENT_UNIT);
            units.push_back(random_hex_unit());
         end
      end
      for (i = 0; i < units.size(); i++) begin
         add_unit(units[i], i == units.size() - 1);
      end
   endtask

   task automatic wait_drained();
      while (unit_backlog.size() != 0 || req_valid || due_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall);
      int sent;
      int prior;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      sent = 0;
      while (sent < PHASE_UNITS) begin
         prior = unit_backlog.size();
         add_random_string();
         sent += unit_backlog.size() - prior;
      end
      wait_drained();
   endtask

   task automatic report_bad(input string what, input decoded_beat_type want,
                             input decoded_beat_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%s: expected char %h has %b last %b, got char %h has %b last %b",
                  what, want.ch, want.has_char, want.last,
                  got.ch, got.has_char, got.last);
      end
   endtask

   // driver: one beat held until accepted, random gaps between beats
   always @(posedge clock) begin : driver
      text_beat_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_unit(req_char, req_last);
         end
         if (!req_valid || req_ready) begin
            if (unit_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               upcoming = unit_backlog.pop_front();
               req_valid <= 1'b1;
               req_char <= upcoming.ch;
               req_last <= upcoming.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stalls, each accepted beat checked against the oldest due one
   always @(posedge clock) begin : monitor
      decoded_beat_type want;
      decoded_beat_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            got.ch = rsp_char;
            got.has_char = rsp_has_char;
            got.last = rsp_last;
            if (due_chars.size() == 0) begin
               report_bad("unexpected beat", '0, got);
            end else begin
               want = due_chars.pop_front();
               if (got.ch !== want.ch || got.has_char !== want.has_char ||
                   got.last !== want.last) begin
                  report_bad("mismatch", want, got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      add_text("%41", 1'b1);
      add_text("%00", 1'b1);
      add_text("%", 1'b1);
      add_text("%4", 1'b1);
      add_text("%4%Ff", 1'b1);
      add_text("%z", 1'b1);
      add_unit(16'h0000, 1'b0);
      add_unit(16'hFFFF, 1'b1);
      add_text("%9", 1'b0);
      add_unit(16'hFFFF, 1'b1);
      add_text("%4%", 1'b1);
      wait_drained();
      run_phase(0, 0);
      run_phase(56, 0);
      run_phase(0, 56);
      run_phase(8, 8);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_chars.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== percent_decoder_stream_unit.f =====
hdl/pds_pkg.sv
hdl/pds_front.sv
hdl/pds_queue.sv
hdl/pds_back.sv
hdl/percent_decoder_stream_unit.sv
verif/percent_decoder_stream_unit_test.sv
